// ----- sv/cdod_pkg.sv -----
package cdod_pkg;

    localparam logic [10:0] FIRST_YEAR = 11'd2000;
    localparam logic [10:0] LAST_YEAR  = 11'd2030;
    localparam logic [4:0]  LAST_YOFF  = 5'd30;
    localparam logic [3:0]  LAST_MONTH = 4'd12;
    localparam logic [13:0] LAST_INDEX = 14'd11322;
    localparam logic [13:0] DAYS_YEAR  = 14'd365;
    localparam logic [13:0] DAYS_LEAP  = 14'd366;

    localparam logic MODE_ADD     = 1'b0;
    localparam logic MODE_COMPARE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_SUM,
        ST_YEAR,
        ST_MONTH,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic calc_index;
        logic calc_sum;
        logic year_step;
        logic month_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mode;
        logic dates_ok;
        logic year_done;
        logic month_done;
        logic out_free;
    } status_t;

    function automatic logic [4:0] days_in_month(input logic leap, input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd2:                       len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
        logic [8:0] base;
        unique case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + 9'((leap && (m > 4'd2)) ? 1 : 0);
    endfunction

    // Days from the first of January 2000 to the first of January of the given year.
    function automatic logic [13:0] year_start(input logic [4:0] yoff);
        logic [13:0] plain;
        logic [5:0]  leaps;
        plain = 14'(yoff) * DAYS_YEAR;
        leaps = ({1'b0, yoff} + 6'd3) >> 2;
        return plain + 14'(leaps);
    endfunction

    function automatic logic date_ok(input logic [10:0] y, input logic [3:0] m,
                                     input logic [4:0] d);
        logic [10:0] yoff;
        logic        leap;
        yoff = y - FIRST_YEAR;
        leap = (y[1:0] == 2'b00);
        return (y >= FIRST_YEAR) && (y <= LAST_YEAR) && (m >= 4'd1) && (m <= LAST_MONTH)
            && (d >= 5'd1) && (d <= days_in_month(leap, m)) && (yoff <= 11'(LAST_YOFF));
    endfunction

    // Zero-based day number from 2000-01-01; meaningful for valid dates only.
    function automatic logic [13:0] day_index(input logic [10:0] y, input logic [3:0] m,
                                              input logic [4:0] d);
        logic [10:0] yfull;
        logic [4:0]  yoff;
        logic        leap;
        yfull = y - FIRST_YEAR;
        yoff  = yfull[4:0];
        leap  = (y[1:0] == 2'b00);
        return year_start(yoff) + 14'(month_start(leap, m)) + 14'(d) - 14'd1;
    endfunction

endpackage

// ----- sv/calendar_date_offset_and_difference_top.sv -----
// Compare mode and invalid dates pass from the accepted word through the index, sum and finish
// states to out_valid. Add mode also walks the years and then the months of the result date
// between the sum and finish states; finish waits while the output register holds a stalled result.
// Throughput: one word at a time; the next word can be accepted once the result is placed in the
// output register, even while that result still waits for out_ready.
// Reset: rst_n is asynchronous and active low; it returns the controller to idle and drops out_valid.
module calendar_date_offset_and_difference_top
    import cdod_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic [10:0]        year_a,
    input  logic [3:0]         month_a,
    input  logic [4:0]         day_a,
    input  logic signed [14:0] offset,
    input  logic [10:0]        year_b,
    input  logic [3:0]         month_b,
    input  logic [4:0]         day_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               dates_valid,
    output logic               range_error,
    output logic [10:0]        res_year,
    output logic [3:0]         res_month,
    output logic [4:0]         res_day,
    output logic [13:0]        day_distance,
    output logic               a_earlier,
    output logic               a_same
);

    // The controller sequences each word through index, sum, year walk and month walk (add mode
    // with valid dates only) and finish. The datapath holds the captured word, the day numbers, the
    // remaining day count of the walk and the output register.
    cmd_t    cmd;
    status_t status;

    cdod_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The year walk subtracts a whole year per cycle from the clamped day number,
    // then the month walk subtracts whole months; what remains is the day of month.
    cdod_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode),
        .year_a       (year_a),
        .month_a      (month_a),
        .day_a        (day_a),
        .offset       (offset),
        .year_b       (year_b),
        .month_b      (month_b),
        .day_b        (day_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dates_valid  (dates_valid),
        .range_error  (range_error),
        .res_year     (res_year),
        .res_month    (res_month),
        .res_day      (res_day),
        .day_distance (day_distance),
        .a_earlier    (a_earlier),
        .a_same       (a_same)
    );

endmodule

// ----- sv/cdod_ctrl.sv -----
module cdod_ctrl
    import cdod_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_INDEX;
                end
            end
            ST_INDEX:
            begin
                cmd.calc_index = 1'b1;
                state_next     = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                if (status.dates_ok && (status.mode == MODE_ADD))
                begin
                    state_next = ST_YEAR;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_YEAR:
            begin
                if (status.year_done)
                begin
                    state_next = ST_MONTH;
                end
                else
                begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH:
            begin
                if (status.month_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/cdod_datapath.sv -----
module cdod_datapath
    import cdod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        mode,
    input  logic [10:0] year_a,
    input  logic [3:0]  month_a,
    input  logic [4:0]  day_a,
    input  logic signed [14:0] offset,
    input  logic [10:0] year_b,
    input  logic [3:0]  month_b,
    input  logic [4:0]  day_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        dates_valid,
    output logic        range_error,
    output logic [10:0] res_year,
    output logic [3:0]  res_month,
    output logic [4:0]  res_day,
    output logic [13:0] day_distance,
    output logic        a_earlier,
    output logic        a_same
);

    // Captured word.
    logic               mode_reg;
    logic [10:0]        year_a_reg, year_b_reg;
    logic [3:0]         month_a_reg, month_b_reg;
    logic [4:0]         day_a_reg, day_b_reg;
    logic signed [14:0] offset_reg;

    // Working registers.
    logic [13:0] na_reg, nb_reg;
    logic        ok_reg;
    logic [13:0] rem_reg;
    logic [4:0]  yy_reg;
    logic [3:0]  mm_reg;
    logic        rerr_reg;
    logic [13:0] dist_reg;
    logic        earlier_reg;
    logic        same_reg;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic        dates_valid_reg;
    logic        range_error_reg;
    logic [10:0] res_year_reg;
    logic [3:0]  res_month_reg;
    logic [4:0]  res_day_reg;
    logic [13:0] day_distance_reg;
    logic        a_earlier_reg;
    logic        a_same_reg;

    logic signed [15:0] sum_n;
    logic [13:0]        len_year;
    logic [13:0]        len_month;
    logic               leap_yy;

    assign sum_n     = signed'({2'b00, na_reg}) + 16'(offset_reg);
    assign leap_yy   = (yy_reg[1:0] == 2'b00);
    assign len_year  = leap_yy ? DAYS_LEAP : DAYS_YEAR;
    assign len_month = 14'(days_in_month(leap_yy, mm_reg));

    assign status.mode       = mode_reg;
    assign status.dates_ok   = ok_reg;
    assign status.year_done  = (rem_reg < len_year) || (yy_reg == LAST_YOFF);
    assign status.month_done = (rem_reg < len_month) || (mm_reg == LAST_MONTH);
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            year_a_reg  <= year_a;
            month_a_reg <= month_a;
            day_a_reg   <= day_a;
            offset_reg  <= offset;
            year_b_reg  <= year_b;
            month_b_reg <= month_b;
            day_b_reg   <= day_b;
        end
        if (cmd.calc_index)
        begin
            na_reg <= day_index(year_a_reg, month_a_reg, day_a_reg);
            nb_reg <= day_index(year_b_reg, month_b_reg, day_b_reg);
            ok_reg <= date_ok(year_a_reg, month_a_reg, day_a_reg)
                      && ((mode_reg == MODE_ADD)
                          || date_ok(year_b_reg, month_b_reg, day_b_reg));
        end
        if (cmd.calc_sum)
        begin
            yy_reg      <= 5'd0;
            mm_reg      <= 4'd1;
            dist_reg    <= (na_reg >= nb_reg) ? (na_reg - nb_reg) : (nb_reg - na_reg);
            earlier_reg <= (na_reg < nb_reg);
            same_reg    <= (na_reg == nb_reg);
            if (sum_n < 16'sd0)
            begin
                rem_reg  <= 14'd0;
                rerr_reg <= 1'b1;
            end
            else if (sum_n > signed'({2'b00, LAST_INDEX}))
            begin
                rem_reg  <= LAST_INDEX;
                rerr_reg <= 1'b1;
            end
            else
            begin
                rem_reg  <= sum_n[13:0];
                rerr_reg <= 1'b0;
            end
        end
        if (cmd.year_step)
        begin
            rem_reg <= rem_reg - len_year;
            yy_reg  <= yy_reg + 5'd1;
        end
        if (cmd.month_step)
        begin
            rem_reg <= rem_reg - len_month;
            mm_reg  <= mm_reg + 4'd1;
        end
        if (cmd.out_load)
        begin
            dates_valid_reg <= ok_reg;
            if (ok_reg && (mode_reg == MODE_ADD))
            begin
                range_error_reg  <= rerr_reg;
                res_year_reg     <= FIRST_YEAR + 11'(yy_reg);
                res_month_reg    <= mm_reg;
                res_day_reg      <= 5'(rem_reg + 14'd1);
                day_distance_reg <= 14'd0;
                a_earlier_reg    <= 1'b0;
                a_same_reg       <= 1'b0;
            end
            else if (ok_reg)
            begin
                range_error_reg  <= 1'b0;
                res_year_reg     <= 11'd0;
                res_month_reg    <= 4'd0;
                res_day_reg      <= 5'd0;
                day_distance_reg <= dist_reg;
                a_earlier_reg    <= earlier_reg;
                a_same_reg       <= same_reg;
            end
            else
            begin
                range_error_reg  <= 1'b0;
                res_year_reg     <= 11'd0;
                res_month_reg    <= 4'd0;
                res_day_reg      <= 5'd0;
                day_distance_reg <= 14'd0;
                a_earlier_reg    <= 1'b0;
                a_same_reg       <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign dates_valid  = dates_valid_reg;
    assign range_error  = range_error_reg;
    assign res_year     = res_year_reg;
    assign res_month    = res_month_reg;
    assign res_day      = res_day_reg;
    assign day_distance = day_distance_reg;
    assign a_earlier    = a_earlier_reg;
    assign a_same       = a_same_reg;

endmodule

// ----- sv/cdod_checker.sv -----
module cdod_checker
    import cdod_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               dates_valid,
    input logic               range_error,
    input logic [10:0]        res_year,
    input logic [3:0]         res_month,
    input logic [4:0]         res_day,
    input logic [13:0]        day_distance,
    input logic               a_earlier,
    input logic               a_same
);

    // A stalled result stays valid and its date, distance and dates_valid fields hold.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_year) && $stable(res_month)
            && $stable(res_day) && $stable(day_distance) && $stable(dates_valid))
        else $error("result word changed while stalled");

    // An accepted word keeps the input closed for at least the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after a word was accepted");

    // Invalid dates give an all-zero result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !dates_valid |-> !range_error && res_year == 11'd0 && res_month == 4'd0
            && res_day == 5'd0 && day_distance == 14'd0 && !a_earlier && !a_same)
        else $error("invalid dates gave a nonzero result");

    // Equal dates are neither apart nor ordered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && a_same |-> day_distance == 14'd0 && !a_earlier)
        else $error("equal dates reported apart or ordered");

    // A clamped result sits on one end of the span.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> dates_valid
            && ((res_year == FIRST_YEAR && res_month == 4'd1 && res_day == 5'd1)
                || (res_year == LAST_YEAR && res_month == 4'd12 && res_day == 5'd31)))
        else $error("clamped result not at an end of the span");

endmodule

bind calendar_date_offset_and_difference_top cdod_checker u_cdod_checker (.*);
